// File: rtl/core/utm_pkg.sv
package utm_pkg;

  // Width of the saturating code point counter (8 to 32).
  localparam int CountBits = 16;
  // Width of the reported count; larger counter values show as all ones.
  localparam int ShownBits = 16;

  localparam int CpBits = 21;

  localparam logic [7:0] NulByte = 8'h00;
  localparam logic [7:0] EscByte = 8'h1b;
  localparam logic [7:0] EscEnd  = 8'h6d;  // 'm' closes an escape sequence

  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Code = 8'hf0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Code = 8'he0;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Code = 8'hc0;

  localparam logic [2:0] Len1 = 3'd1;
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  localparam logic [1:0] ColsNone = 2'd0;
  localparam logic [1:0] ColsOne  = 2'd1;
  localparam logic [1:0] ColsTwo  = 2'd2;

  // Depth of the queue between the decoder and the output stage.
  localparam int FifoDepth   = 2;
  localparam int FifoPtrBits = $clog2(FifoDepth);
  localparam int FifoCntBits = $clog2(FifoDepth + 1);

  localparam int NumWide = 121;
  typedef logic [CpBits-1:0] cp_t;

  // Inclusive intervals of double-width code points: {low, high}.
  localparam cp_t WideLo [NumWide] = '{
    21'h1100, 21'h231a, 21'h2329, 21'h23e9, 21'h23f0, 21'h23f3, 21'h25fd, 21'h2614,
    21'h2648, 21'h267f, 21'h2693, 21'h26a1, 21'h26aa, 21'h26bd, 21'h26c4, 21'h26ce,
    21'h26d4, 21'h26ea, 21'h26f2, 21'h26f5, 21'h26fa, 21'h26fd, 21'h2705, 21'h270a,
    21'h2728, 21'h274c, 21'h274e, 21'h2753, 21'h2757, 21'h2795, 21'h27b0, 21'h27bf,
    21'h2b1b, 21'h2b50, 21'h2b55, 21'h2e80, 21'h2e9b, 21'h2f00, 21'h2ff0, 21'h3000,
    21'h3041, 21'h3099, 21'h3105, 21'h3131, 21'h3190, 21'h31f0, 21'h3220, 21'h3250,
    21'h4e00, 21'ha490, 21'ha960, 21'hac00, 21'hf900, 21'hfe10, 21'hfe30, 21'hfe54,
    21'hfe68, 21'hff01, 21'hffe0, 21'h16fe0, 21'h16ff0, 21'h17000, 21'h18800, 21'h18d00,
    21'h1aff0, 21'h1aff5, 21'h1affd, 21'h1b000, 21'h1b150, 21'h1b164, 21'h1b170, 21'h1f004,
    21'h1f0cf, 21'h1f18e, 21'h1f191, 21'h1f200, 21'h1f210, 21'h1f240, 21'h1f250, 21'h1f260,
    21'h1f300, 21'h1f32d, 21'h1f337, 21'h1f37e, 21'h1f3a0, 21'h1f3cf, 21'h1f3e0, 21'h1f3f4,
    21'h1f3f8, 21'h1f440, 21'h1f442, 21'h1f4ff, 21'h1f54b, 21'h1f550, 21'h1f57a, 21'h1f595,
    21'h1f5a4, 21'h1f5fb, 21'h1f680, 21'h1f6cc, 21'h1f6d0, 21'h1f6d5, 21'h1f6dd, 21'h1f6eb,
    21'h1f6f4, 21'h1f7e0, 21'h1f7f0, 21'h1f90c, 21'h1f93c, 21'h1f947, 21'h1fa70, 21'h1fa78,
    21'h1fa80, 21'h1fa90, 21'h1fab0, 21'h1fac0, 21'h1fad0, 21'h1fae0, 21'h1faf0, 21'h20000,
    21'h30000
  };

  localparam cp_t WideHi [NumWide] = '{
    21'h115f, 21'h231b, 21'h232a, 21'h23ec, 21'h23f0, 21'h23f3, 21'h25fe, 21'h2615,
    21'h2653, 21'h267f, 21'h2693, 21'h26a1, 21'h26ab, 21'h26be, 21'h26c5, 21'h26ce,
    21'h26d4, 21'h26ea, 21'h26f3, 21'h26f5, 21'h26fa, 21'h26fd, 21'h2705, 21'h270b,
    21'h2728, 21'h274c, 21'h274e, 21'h2755, 21'h2757, 21'h2797, 21'h27b0, 21'h27bf,
    21'h2b1c, 21'h2b50, 21'h2b55, 21'h2e99, 21'h2ef3, 21'h2fd5, 21'h2ffb, 21'h303e,
    21'h3096, 21'h30ff, 21'h312f, 21'h318e, 21'h31e3, 21'h321e, 21'h3247, 21'h4dbf,
    21'ha48c, 21'ha4c6, 21'ha97c, 21'hd7a3, 21'hfaff, 21'hfe19, 21'hfe52, 21'hfe66,
    21'hfe6b, 21'hff60, 21'hffe6, 21'h16fe4, 21'h16ff1, 21'h187f7, 21'h18cd5, 21'h18d08,
    21'h1aff3, 21'h1affb, 21'h1affe, 21'h1b122, 21'h1b152, 21'h1b167, 21'h1b2fb, 21'h1f004,
    21'h1f0cf, 21'h1f18e, 21'h1f19a, 21'h1f202, 21'h1f23b, 21'h1f248, 21'h1f251, 21'h1f265,
    21'h1f320, 21'h1f335, 21'h1f37c, 21'h1f393, 21'h1f3ca, 21'h1f3d3, 21'h1f3f0, 21'h1f3f4,
    21'h1f43e, 21'h1f440, 21'h1f4fc, 21'h1f53d, 21'h1f54e, 21'h1f567, 21'h1f57a, 21'h1f596,
    21'h1f5a4, 21'h1f64f, 21'h1f6c5, 21'h1f6cc, 21'h1f6d2, 21'h1f6d7, 21'h1f6df, 21'h1f6ec,
    21'h1f6fc, 21'h1f7eb, 21'h1f7f0, 21'h1f93a, 21'h1f945, 21'h1f9ff, 21'h1fa74, 21'h1fa7c,
    21'h1fa86, 21'h1faac, 21'h1faba, 21'h1fac5, 21'h1fad9, 21'h1fae7, 21'h1faf6, 21'h2fffd,
    21'h3fffd
  };

  // One decoded word on its way from the decoder to the output stage.
  typedef struct packed {
    logic                 cp_ready;
    cp_t                  code_point;
    logic [2:0]           cp_bytes;
    logic                 string_done;
    logic [ShownBits-1:0] char_count;
  } utm_item_t;

  // Terminal columns of a code point: every interval is compared in parallel.
  function automatic logic [1:0] columns_of(input cp_t cp);
    logic wide;
    wide = 1'b0;
    for (int i = 0; i < NumWide; i++) begin
      if (cp >= WideLo[i] && cp <= WideHi[i]) begin
        wide = 1'b1;
      end
    end
    if (cp == '0) begin
      return ColsNone;
    end else if (wide) begin
      return ColsTwo;
    end
    return ColsOne;
  endfunction

endpackage

// File: rtl/core/utf8_text_measure.sv
// Channel   Handshake            Word fields
// input     push / full          text_byte[7:0], is_last
// result    empty / pop          cp_ready, code_point[20:0], cp_bytes[2:0],
//                                display_width[1:0], string_done, char_count[15:0]
//
// One result word per input word, one word per cycle sustained while the result side keeps popping.
// From push to the ports, a word is held first in the queue, which the
// decoder writes in the accept cycle, and then in the output register,
// which the width table lookup fills from the queue head.
// Synchronous active-high reset empties the queue and output register and
// clears the decoder state. A stalled result side fills the two-entry queue
// and then raises full; the output register is refilled in the same cycle
// it is popped, so no bubble appears.
module utf8_text_measure import utm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           text_byte,
  input  logic                 is_last,
  output logic                 empty,
  input  logic                 pop,
  output logic                 cp_ready,
  output logic [CpBits-1:0]    code_point,
  output logic [2:0]           cp_bytes,
  output logic [1:0]           display_width,
  output logic                 string_done,
  output logic [ShownBits-1:0] char_count
);

  // The decoder advances only on an accepted word. It strips escape
  // sequences, assembles multi-byte code points and keeps the per-string
  // counter; the word it produces carries everything except the width.
  utm_item_t front_item;
  utm_item_t q_item;
  logic      take;
  logic      q_empty;
  logic      q_pop;

  assign take = push && !full;

  utm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_byte (text_byte),
    .is_last   (is_last),
    .item      (front_item)
  );

  // The queue lets the decoder keep taking words while the consumer stalls.
  utm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  // The back end looks up the display width and holds the result word.
  utm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .cp_ready      (cp_ready),
    .code_point    (code_point),
    .cp_bytes      (cp_bytes),
    .display_width (display_width),
    .string_done   (string_done),
    .char_count    (char_count)
  );

endmodule

// File: rtl/core/utm_front.sv
module utm_front import utm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  logic [7:0] text_byte,
  input  logic      is_last,
  output utm_item_t item
);

  logic                 in_escape, in_escape_next;
  logic [1:0]           bytes_remaining, bytes_remaining_next;
  logic [2:0]           seq_length, seq_length_next;
  cp_t                  cp_accumulator, cp_accumulator_next;
  logic [CountBits-1:0] cp_counter, cp_counter_next;
  logic                 ready;
  logic                 done;
  logic [31:0]          count_wide;

  always_comb begin
    in_escape_next       = in_escape;
    bytes_remaining_next = bytes_remaining;
    seq_length_next      = seq_length;
    cp_accumulator_next  = cp_accumulator;
    cp_counter_next      = cp_counter;
    ready                = 1'b0;
    done                 = (text_byte == NulByte) || is_last;

    if (text_byte == NulByte) begin
      // A zero byte only ends the string.
    end else if (in_escape) begin
      if (text_byte == EscEnd) begin
        in_escape_next = 1'b0;
      end
    end else if (text_byte == EscByte) begin
      in_escape_next = 1'b1;
    end else if (bytes_remaining == 2'd0) begin
      if ((text_byte & Lead4Mask) == Lead4Code) begin
        seq_length_next     = Len4;
        cp_accumulator_next = CpBits'(text_byte[2:0]);
      end else if ((text_byte & Lead3Mask) == Lead3Code) begin
        seq_length_next     = Len3;
        cp_accumulator_next = CpBits'(text_byte[3:0]);
      end else if ((text_byte & Lead2Mask) == Lead2Code) begin
        seq_length_next     = Len2;
        cp_accumulator_next = CpBits'(text_byte[4:0]);
      end else begin
        seq_length_next     = Len1;
        cp_accumulator_next = CpBits'(text_byte);
      end
      bytes_remaining_next = 2'(seq_length_next - 3'd1);
      ready                = (seq_length_next == Len1);
    end else begin
      // Continuation position: low six bits are taken without checking.
      cp_accumulator_next  = {cp_accumulator[CpBits-7:0], text_byte[5:0]};
      bytes_remaining_next = bytes_remaining - 2'd1;
      ready                = (bytes_remaining == 2'd1);
    end

    if (ready && cp_counter != '1) begin
      cp_counter_next = cp_counter + 1'b1;
    end
  end

  assign count_wide = 32'(cp_counter_next);

  always_comb begin
    item.cp_ready    = ready;
    item.code_point  = ready ? cp_accumulator_next : '0;
    item.cp_bytes    = ready ? seq_length_next : 3'd0;
    item.string_done = done;
    item.char_count  = (|count_wide[31:ShownBits]) ? '1 : count_wide[ShownBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape       <= 1'b0;
      bytes_remaining <= 2'd0;
      seq_length      <= 3'd0;
      cp_accumulator  <= '0;
      cp_counter      <= '0;
    end else if (take) begin
      if (done) begin
        in_escape       <= 1'b0;
        bytes_remaining <= 2'd0;
        seq_length      <= 3'd0;
        cp_accumulator  <= '0;
        cp_counter      <= '0;
      end else begin
        in_escape       <= in_escape_next;
        bytes_remaining <= bytes_remaining_next;
        seq_length      <= seq_length_next;
        cp_accumulator  <= cp_accumulator_next;
        cp_counter      <= cp_counter_next;
      end
    end
  end

endmodule

// File: rtl/core/utm_fifo.sv
module utm_fifo import utm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  utm_item_t wr_item,
  output logic      full,
  input  logic      rd_en,
  output utm_item_t rd_item,
  output logic      empty
);

  utm_item_t              mem [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr;
  logic [FifoPtrBits-1:0] rd_ptr;
  logic [FifoCntBits-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign full    = (count == FifoCntBits'(FifoDepth));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == FifoPtrBits'(FifoDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == FifoPtrBits'(FifoDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/utm_back.sv
module utm_back import utm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  utm_item_t            q_item,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic                 cp_ready,
  output logic [CpBits-1:0]    code_point,
  output logic [2:0]           cp_bytes,
  output logic [1:0]           display_width,
  output logic                 string_done,
  output logic [ShownBits-1:0] char_count
);

  logic out_valid;
  logic load;

  assign empty = !out_valid;
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Width lookup runs on the queue head and lands with the rest of the word.
  always_ff @(posedge clk) begin
    if (load) begin
      cp_ready      <= q_item.cp_ready;
      code_point    <= q_item.code_point;
      cp_bytes      <= q_item.cp_bytes;
      display_width <= q_item.cp_ready ? columns_of(q_item.code_point) : ColsNone;
      string_done   <= q_item.string_done;
      char_count    <= q_item.char_count;
    end
  end

endmodule
